>>> rtl/dd_pkg.sv
// Shared types, constants and status codes of the pairwise DNA distance unit.
`default_nettype none
package dd_pkg;

  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int IN_COUNT_BITS     = 32;
  localparam int DIST_BITS         = 48;
  localparam int LOG_FRAC          = 30;
  localparam int LOG_Y_BITS        = LOG_FRAC + 1;
  // The log difference is cut to 24 fraction bits before scaling.
  localparam int LOG_KEEP          = 24;
  localparam int LN2X3_BITS        = 34;
  // Three times ln 2 in Q2.32.
  localparam logic [LN2X3_BITS-1:0] LN2_X3 = 34'h2_1456_47E8;
  // The scaled product has 56 fraction bits and carries a factor of four.
  localparam int PROD_POINT        = 58;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [1:0] MODEL_MUT = 2'd0;
  localparam logic [1:0] MODEL_TV  = 2'd1;
  localparam logic [1:0] MODEL_JC  = 2'd2;

  typedef struct packed {
    logic [IN_COUNT_BITS-1:0] mutation_count;
    logic [IN_COUNT_BITS-1:0] identical_count;
    logic [IN_COUNT_BITS-1:0] transversion_count;
    logic                     same_pair;
  } in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [1:0]           status;
  } out_t;

  // Control that travels beside the log pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 use_log;
    logic [DIST_BITS-1:0] distance;
    logic [1:0]           status;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/dd_front.sv
// Input stage: count masking, site totals, log operands and raw-count results.
`default_nettype none
module dd_front import dd_pkg::*; #(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int AW            = COUNT_WIDTH_DEF + 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire in_t           item,
  input  wire logic [1:0]    model,
  output side_t              side,
  output logic [AW-1:0]      a_val,
  output logic [AW-1:0]      amb_val
);

  localparam int EFF = (COUNT_WIDTH < IN_COUNT_BITS) ? COUNT_WIDTH : IN_COUNT_BITS;
  localparam int RAW_LIMIT = DIST_BITS - FRACTION_BITS;

  logic [AW-1:0] m, idn, n, a, b;
  logic [63:0]   raw_c;
  logic [63:0]   raw_sh;
  side_t         side_next;

  always_comb begin
    m   = {{(AW-EFF){1'b0}}, item.mutation_count[EFF-1:0]};
    idn = {{(AW-EFF){1'b0}}, item.identical_count[EFF-1:0]};
    n   = m + idn;
    a   = n + (n << 1);
    b   = m << 2;

    raw_c = (model == MODEL_TV) ? {{(64-EFF){1'b0}}, item.transversion_count[EFF-1:0]}
                                : {{(64-EFF){1'b0}}, item.mutation_count[EFF-1:0]};
    raw_sh = raw_c << FRACTION_BITS;

    side_next.valid    = in_valid;
    side_next.use_log  = 1'b0;
    side_next.distance = '0;
    side_next.status   = ST_VALID;
    if (!item.same_pair) begin
      unique case (model)
        MODEL_MUT, MODEL_TV: begin
          if ((raw_c >> RAW_LIMIT) != 64'd0) begin
            side_next.distance = '1;
            side_next.status   = ST_SAT;
          end else begin
            side_next.distance = raw_sh[DIST_BITS-1:0];
          end
        end
        MODEL_JC: begin
          if (n == '0 || b > a) begin
            side_next.status = ST_UNDEF;
          end else if (b != a) begin
            side_next.use_log = 1'b1;
          end
        end
        default: begin
          side_next.status = ST_UNDEF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else begin
      side <= side_next;
    end
    a_val   <= a;
    amb_val <= a - b;
  end

endmodule
`default_nettype wire

>>> rtl/dd_sqr_stage.sv
// One squaring step of the log2 fraction: square, renormalize, emit one bit.
`default_nettype none
module dd_sqr_stage import dd_pkg::*; #(
  parameter int EW = 6
) (
  input  wire logic                  clk,
  input  wire logic [LOG_Y_BITS-1:0] y_in,
  input  wire logic [LOG_FRAC-1:0]   frac_in,
  input  wire logic [EW-1:0]         e_in,
  output logic [LOG_Y_BITS-1:0]      y_out,
  output logic [LOG_FRAC-1:0]        frac_out,
  output logic [EW-1:0]              e_out
);

  logic [2*LOG_Y_BITS-1:0] sq;
  logic [LOG_Y_BITS:0]     t;

  always_comb begin
    sq = y_in * y_in;
    t  = sq[2*LOG_Y_BITS-1:LOG_FRAC];
  end

  always_ff @(posedge clk) begin
    y_out    <= t[LOG_Y_BITS] ? t[LOG_Y_BITS:1] : t[LOG_Y_BITS-1:0];
    frac_out <= {frac_in[LOG_FRAC-2:0], t[LOG_Y_BITS]};
    e_out    <= e_in;
  end

endmodule
`default_nettype wire

>>> rtl/dd_log2.sv
// Pipelined log2 in Q.30: leading-one search, normalize, then one squaring per stage.
`default_nettype none
module dd_log2 import dd_pkg::*; #(
  parameter int AW = COUNT_WIDTH_DEF + 3,
  parameter int EW = $clog2(AW)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    x_in,
  output logic [EW+LOG_FRAC-1:0] log_out
);

  localparam int NW = (AW > LOG_Y_BITS) ? AW : LOG_Y_BITS;
  localparam int SW = $clog2(NW);

  logic [EW-1:0]         e_det, e1, e2;
  logic [AW-1:0]         x1;
  logic [NW-1:0]         xs;
  logic [SW-1:0]         sh;
  logic [LOG_Y_BITS-1:0] y2;

  logic [LOG_Y_BITS-1:0] y_ch [LOG_FRAC+1];
  logic [LOG_FRAC-1:0]   f_ch [LOG_FRAC+1];
  logic [EW-1:0]         e_ch [LOG_FRAC+1];

  always_comb begin
    e_det = '0;
    for (int i = 0; i < AW; i++) begin
      if (x_in[i]) e_det = EW'(i);
    end
  end

  always_comb begin
    sh = SW'(NW-1) - SW'(e1);
    xs = {{(NW-AW){1'b0}}, x1} << sh;
  end

  always_ff @(posedge clk) begin
    e1 <= e_det;
    x1 <= x_in;
    e2 <= e1;
    y2 <= xs[NW-1 -: LOG_Y_BITS];
  end

  assign y_ch[0] = y2;
  assign f_ch[0] = '0;
  assign e_ch[0] = e2;

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    dd_sqr_stage #(.EW(EW)) u_stage (
      .clk      (clk),
      .y_in     (y_ch[k]),
      .frac_in  (f_ch[k]),
      .e_in     (e_ch[k]),
      .y_out    (y_ch[k+1]),
      .frac_out (f_ch[k+1]),
      .e_out    (e_ch[k+1])
    );
  end

  assign log_out = {e_ch[LOG_FRAC], f_ch[LOG_FRAC]};

endmodule
`default_nettype wire

>>> rtl/dd_back.sv
// Output stages: log difference, scaling by 0.75 ln 2, result selection.
`default_nettype none
module dd_back import dd_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int LW            = 36
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire side_t         side_in,
  input  wire logic [LW-1:0] la,
  input  wire logic [LW-1:0] lb,
  output out_t               result,
  output logic               done
);

  localparam int RW = LW - (LOG_FRAC - LOG_KEEP);
  localparam int PW = RW + LN2X3_BITS;
  localparam int SHIFT = PROD_POINT - FRACTION_BITS;

  side_t          s1, s2;
  logic [RW-1:0]  lr;
  logic [PW-1:0]  prod, scaled;
  logic [LW-1:0]  diff;

  always_comb begin
    diff   = (la > lb) ? (la - lb) : '0;
    scaled = prod >> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1.valid <= side_in.valid;
      s2.valid <= s1.valid;
      done     <= s2.valid;
    end
    s1.use_log  <= side_in.use_log;
    s1.distance <= side_in.distance;
    s1.status   <= side_in.status;
    s2.use_log  <= s1.use_log;
    s2.distance <= s1.distance;
    s2.status   <= s1.status;
    lr   <= diff[LW-1:LOG_FRAC-LOG_KEEP];
    prod <= lr * LN2_X3;
    if (s2.use_log) begin
      result.distance <= scaled[DIST_BITS-1:0];
      result.status   <= ST_VALID;
    end else begin
      result.distance <= s2.distance;
      result.status   <= s2.status;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pairwise_dna_distance.sv
// Top level of the pairwise DNA distance unit.
// One item (a population pair's mutation, identical and transversion counts and a
// diagonal flag) is taken every clock cycle: busy is always low, so an item is
// accepted at every edge with start high. Each item yields exactly one result,
// shown on result for one cycle with done high; the receiver cannot stall, and
// results come out in item order. The pipeline holds one input stage, the log2
// units, which spend one stage on the leading-one search, one on normalizing and
// one per fraction bit on squaring (30 stages), and three output stages. distance
// is unsigned fixed point with FRACTION_BITS fraction bits; status is valid,
// undefined (negative log argument, no sites or unused model) or saturated.
// distance_model is to be written through cfg_we and cfg_data by the user only
// while no item is in flight; the block itself does not enforce this.
`default_nettype none
module pairwise_dna_distance import dd_pkg::*; #(
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        item,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_data,
  output out_t            result,
  output logic            done
);

  localparam int EFF = (COUNT_WIDTH < IN_COUNT_BITS) ? COUNT_WIDTH : IN_COUNT_BITS;
  // Three times the site total needs three bits more than one count.
  localparam int AW = EFF + 3;
  localparam int EW = $clog2(AW);
  localparam int LW = EW + LOG_FRAC;
  // Leading-one search, normalize, then one stage per fraction bit.
  localparam int LOG_LAT = LOG_FRAC + 2;

  logic [1:0]    distance_model;
  side_t         side0;
  logic [AW-1:0] a_val, amb_val;
  logic [LW-1:0] la, lb;
  side_t         side_line [LOG_LAT];

  // The pipeline never stalls, so an item can enter at every edge.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_model <= MODEL_MUT;
    end else if (cfg_we) begin
      distance_model <= cfg_data;
    end
  end

  dd_front #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .AW            (AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .item     (item),
    .model    (distance_model),
    .side     (side0),
    .a_val    (a_val),
    .amb_val  (amb_val)
  );

  // Both logs run side by side; la - lb is log2 of the inverse log argument.
  dd_log2 #(.AW(AW), .EW(EW)) u_log_a (
    .clk     (clk),
    .x_in    (a_val),
    .log_out (la)
  );

  dd_log2 #(.AW(AW), .EW(EW)) u_log_b (
    .clk     (clk),
    .x_in    (amb_val),
    .log_out (lb)
  );

  // The control of each item keeps pace with its operands in the log units.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOG_LAT; i++) begin
        side_line[i] <= '0;
      end
    end else begin
      side_line[0] <= side0;
      for (int i = 1; i < LOG_LAT; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  dd_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .LW            (LW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .side_in (side_line[LOG_LAT-1]),
    .la      (la),
    .lb      (lb),
    .result  (result),
    .done    (done)
  );

endmodule
`default_nettype wire
